/* rtl/lfu_kv_pkg.sv */
// Shared types and constants for the LFU key/value cache.
// No dependencies; used by lfu_kv_ctrl, lfu_kv_dp and the top level.
`default_nettype none

package lfu_kv_pkg;

  localparam int ENTRIES_DEF = 16;
  localparam int KEY_W       = 32;
  localparam int VAL_W       = 32;
  localparam int CNT_W       = 16;
  localparam int STAMP_W     = 32;
  localparam int CAP_W       = 5;

  localparam logic [CAP_W-1:0]   CAP_RST   = CAP_W'(16);
  localparam logic [CNT_W-1:0]   COUNT_MAX = '1;
  localparam logic [CNT_W-1:0]   COUNT_ONE = CNT_W'(1);
  localparam logic [VAL_W-1:0]   MISS_DATA = '1;
  localparam logic [VAL_W-1:0]   PUT_DATA  = '0;

  localparam logic REQ_GET = 1'b0;
  localparam logic REQ_PUT = 1'b1;

  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [VAL_W-1:0]   value;
    logic [CNT_W-1:0]   count;
    logic [STAMP_W-1:0] stamp;
  } entry_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COMMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic out_free;
  } ctrl_sts_t;

endpackage

`default_nettype wire

/* rtl/lfu_kv_ctrl.sv */
// Sequencer for the LFU key/value cache: accept, scan, commit.
// Depends on lfu_kv_pkg; drives the datapath lfu_kv_dp through ctrl_cmd_t.
`default_nettype none

module lfu_kv_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire lfu_kv_pkg::ctrl_sts_t sts,
  output lfu_kv_pkg::ctrl_cmd_t      cmd
);

  lfu_kv_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lfu_kv_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    in_tready  = 1'b0;
    unique case (state_r)
      lfu_kv_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = lfu_kv_pkg::ST_SCAN;
        end
      end
      lfu_kv_pkg::ST_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_done) begin
          state_nxt = lfu_kv_pkg::ST_COMMIT;
        end
      end
      lfu_kv_pkg::ST_COMMIT: begin
        // hold until the result register can take the new transaction
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = lfu_kv_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = lfu_kv_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

/* rtl/lfu_kv_dp.sv */
// Datapath of the LFU key/value cache: entry memory, valid bits, scan
// compare, commit write-back, capacity register and result register.
// Depends on lfu_kv_pkg; commanded by lfu_kv_ctrl.
`default_nettype none

module lfu_kv_dp #(
  parameter int ENTRIES = lfu_kv_pkg::ENTRIES_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire lfu_kv_pkg::ctrl_cmd_t         cmd,
  output lfu_kv_pkg::ctrl_sts_t              sts,
  input  wire logic                          in_tuser,
  input  wire logic [2*lfu_kv_pkg::VAL_W-1:0] in_tdata,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [lfu_kv_pkg::CAP_W-1:0]  cfg_data,
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  output logic                               out_tuser,
  output logic [lfu_kv_pkg::VAL_W-1:0]       out_tdata
);

  localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int USED_W = $clog2(ENTRIES + 1);
  localparam int CMP_W  = (USED_W > lfu_kv_pkg::CAP_W) ? USED_W : lfu_kv_pkg::CAP_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  localparam int KW = lfu_kv_pkg::KEY_W;
  localparam int VW = lfu_kv_pkg::VAL_W;
  localparam int CW = lfu_kv_pkg::CNT_W;
  localparam int SW = lfu_kv_pkg::STAMP_W;

  lfu_kv_pkg::entry_t mem [ENTRIES];
  lfu_kv_pkg::entry_t rd_q;

  logic [ENTRIES-1:0]        valid_r, valid_nxt;
  logic [lfu_kv_pkg::CAP_W-1:0] capacity_r;
  logic [SW-1:0]             touch_clk_r, touch_clk_nxt;

  logic                      req_put_r;
  logic [KW-1:0]             req_key_r;
  logic [VW-1:0]             req_val_r;

  // scan pipeline: issue address, then compare registered read data
  logic [IDX_W-1:0]          scan_idx_r;
  logic                      issued_all_r;
  logic                      cmp_vld_r;
  logic [IDX_W-1:0]          cmp_idx_r;
  logic                      issue;

  // search results
  logic                      hit_r, hit_nxt;
  logic [IDX_W-1:0]          hit_idx_r, hit_idx_nxt;
  logic [VW-1:0]             hit_val_r, hit_val_nxt;
  logic [CW-1:0]             hit_cnt_r, hit_cnt_nxt;
  logic                      free_r, free_nxt;
  logic [IDX_W-1:0]          free_idx_r, free_idx_nxt;
  logic [USED_W-1:0]         used_r, used_nxt;
  logic                      vic_r, vic_nxt;
  logic [IDX_W-1:0]          vic_idx_r, vic_idx_nxt;
  logic [CW-1:0]             vic_cnt_r, vic_cnt_nxt;
  logic [SW-1:0]             vic_age_r, vic_age_nxt;
  logic [SW-1:0]             age;
  logic                      cur_valid;

  // commit
  logic                      wr_en;
  logic [IDX_W-1:0]          wr_addr;
  lfu_kv_pkg::entry_t        wr_entry;
  logic [CW-1:0]             cnt_bump;
  logic                      need_evict;
  logic [IDX_W-1:0]          target;

  logic                      out_valid_r, out_valid_nxt;
  logic                      out_found_r, out_found_nxt;
  logic [VW-1:0]             out_data_r, out_data_nxt;

  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_found_r;
  assign out_tdata  = out_data_r;

  assign issue         = cmd.scan && !issued_all_r;
  assign sts.scan_done = cmp_vld_r && (cmp_idx_r == LAST_IDX);
  assign sts.out_free  = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (issue) begin
      rd_q <= mem[scan_idx_r];
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= lfu_kv_pkg::CAP_RST;
    end else if (cfg_valid && cfg_ready) begin
      capacity_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_put_r <= in_tuser;
      req_key_r <= in_tdata[KW-1:0];
      req_val_r <= in_tdata[2*VW-1:VW];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_idx_r   <= '0;
      issued_all_r <= 1'b0;
      cmp_vld_r    <= 1'b0;
    end else begin
      cmp_vld_r <= issue;
      if (cmd.load) begin
        scan_idx_r   <= '0;
        issued_all_r <= 1'b0;
      end else if (issue) begin
        scan_idx_r <= scan_idx_r + 1'b1;
        if (scan_idx_r == LAST_IDX) begin
          issued_all_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    cmp_idx_r <= scan_idx_r;
  end

  assign cur_valid = valid_r[cmp_idx_r];
  assign age       = touch_clk_r - rd_q.stamp;

  always_comb begin
    hit_nxt      = hit_r;
    hit_idx_nxt  = hit_idx_r;
    hit_val_nxt  = hit_val_r;
    hit_cnt_nxt  = hit_cnt_r;
    free_nxt     = free_r;
    free_idx_nxt = free_idx_r;
    used_nxt     = used_r;
    vic_nxt      = vic_r;
    vic_idx_nxt  = vic_idx_r;
    vic_cnt_nxt  = vic_cnt_r;
    vic_age_nxt  = vic_age_r;
    if (cmd.load) begin
      hit_nxt  = 1'b0;
      free_nxt = 1'b0;
      vic_nxt  = 1'b0;
      used_nxt = '0;
    end else if (cmp_vld_r) begin
      if (cur_valid) begin
        used_nxt = used_r + 1'b1;
        if (!hit_r && rd_q.key == req_key_r) begin
          hit_nxt     = 1'b1;
          hit_idx_nxt = cmp_idx_r;
          hit_val_nxt = rd_q.value;
          hit_cnt_nxt = rd_q.count;
        end
        // lowest count wins, then the largest age; first index on a full tie
        if (!vic_r || rd_q.count < vic_cnt_r ||
            (rd_q.count == vic_cnt_r && age > vic_age_r)) begin
          vic_nxt     = 1'b1;
          vic_idx_nxt = cmp_idx_r;
          vic_cnt_nxt = rd_q.count;
          vic_age_nxt = age;
        end
      end else if (!free_r) begin
        free_nxt     = 1'b1;
        free_idx_nxt = cmp_idx_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r  <= 1'b0;
      free_r <= 1'b0;
      vic_r  <= 1'b0;
      used_r <= '0;
    end else begin
      hit_r  <= hit_nxt;
      free_r <= free_nxt;
      vic_r  <= vic_nxt;
      used_r <= used_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hit_idx_r  <= hit_idx_nxt;
    hit_val_r  <= hit_val_nxt;
    hit_cnt_r  <= hit_cnt_nxt;
    free_idx_r <= free_idx_nxt;
    vic_idx_r  <= vic_idx_nxt;
    vic_cnt_r  <= vic_cnt_nxt;
    vic_age_r  <= vic_age_nxt;
  end

  assign cnt_bump   = (hit_cnt_r == lfu_kv_pkg::COUNT_MAX) ? hit_cnt_r : hit_cnt_r + 1'b1;
  assign need_evict = !free_r || (CMP_W'(used_r) >= CMP_W'(capacity_r));
  assign target     = need_evict ? vic_idx_r : free_idx_r;

  always_comb begin
    wr_en         = 1'b0;
    wr_addr       = hit_idx_r;
    wr_entry      = '{key: req_key_r, value: hit_val_r, count: cnt_bump, stamp: touch_clk_r};
    valid_nxt     = valid_r;
    touch_clk_nxt = touch_clk_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_found_nxt = out_found_r;
    out_data_nxt  = out_data_r;
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
      out_found_nxt = hit_r;
      if (req_put_r == lfu_kv_pkg::REQ_GET) begin
        if (hit_r) begin
          wr_en         = 1'b1;
          out_data_nxt  = hit_val_r;
          touch_clk_nxt = touch_clk_r + 1'b1;
        end else begin
          out_data_nxt = lfu_kv_pkg::MISS_DATA;
        end
      end else begin
        out_data_nxt = lfu_kv_pkg::PUT_DATA;
        if (capacity_r != '0) begin
          wr_en         = 1'b1;
          touch_clk_nxt = touch_clk_r + 1'b1;
          if (hit_r) begin
            wr_entry.value = req_val_r;
          end else begin
            wr_addr           = target;
            wr_entry.value    = req_val_r;
            wr_entry.count    = lfu_kv_pkg::COUNT_ONE;
            valid_nxt[target] = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      touch_clk_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      valid_r     <= valid_nxt;
      touch_clk_r <= touch_clk_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_found_r <= out_found_nxt;
    out_data_r  <= out_data_nxt;
  end

endmodule

`default_nettype wire

/* rtl/lfu_key_value_cache_core.sv */
// Fully associative key/value cache with least-frequently-used replacement
// (oldest last touch breaks ties, then lowest index). One request at a time:
// the request is registered in the idle state, every entry is then read from
// the entry memory once, one per cycle, and compared from the registered read
// data, and the commit state writes the entry back where needed and loads the
// result register once that register is free. A result waiting on out_tready
// does not block acceptance of the next request.
// The capacity register may be written at any time the cache is idle.
// Depends on lfu_kv_pkg, lfu_kv_ctrl and lfu_kv_dp.
`default_nettype none

module lfu_key_value_cache_core #(
  parameter int ENTRIES = lfu_kv_pkg::ENTRIES_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  input  wire logic                           in_tuser,   // req_type
  input  wire logic [2*lfu_kv_pkg::VAL_W-1:0] in_tdata,   // key, value
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [lfu_kv_pkg::CAP_W-1:0]   cfg_data,   // capacity
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  output logic                                out_tuser,  // found
  output logic [lfu_kv_pkg::VAL_W-1:0]        out_tdata   // data
);

  lfu_kv_pkg::ctrl_cmd_t cmd;
  lfu_kv_pkg::ctrl_sts_t sts;

  lfu_kv_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  lfu_kv_dp #(
    .ENTRIES (ENTRIES)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tuser  (out_tuser),
    .out_tdata  (out_tdata)
  );

endmodule

`default_nettype wire
